// ===== design/fdl_pkg.sv =====
// Shared types and constants for the fractional delay line.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fdl_pkg;

   localparam int DEPTH     = 6;
   localparam int SAMPLE_W  = 16;
   localparam int DELAY_W   = 11;
   localparam int FRAC_W    = 8;
   localparam int WHOLE_W   = DELAY_W - FRAC_W;
   localparam int FILL_W    = $clog2(DEPTH + 1);
   localparam int TAP_W     = $clog2(DEPTH);
   localparam int REQ_DATA_W = 32;

   // Q3.8 clamp of 5.0 and the fixed-point form of 0.01
   localparam logic [DELAY_W-1:0] DELAY_MAX = 11'd1280;
   localparam logic [FRAC_W-1:0]  FRAC_MIN  = 8'd3;

   typedef enum logic [0:0] {
      KIND_PUSH = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic       push;
      sample_type sample;
   } push_type;

   typedef struct packed {
      sample_type value;
      logic       enough;
   } result_type;

endpackage

// ===== design/fdl_tap_line.sv =====
// Shift line of DEPTH sample taps and the saturating fill count.
// Depends on fdl_pkg.
`timescale 1ns / 1ps

module fdl_tap_line
   import fdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   output sample_type         taps [DEPTH],
   output logic [FILL_W-1:0]  fill
);

   sample_type        taps_ff [DEPTH];
   sample_type        taps_in [DEPTH];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   // tap k holds the sample pushed k pushes before the newest one
   always_comb begin
      taps_in = taps_ff;
      fill_in = fill_ff;
      if (push.push) begin
         taps_in[0] = push.sample;
         for (int i = 1; i < DEPTH; i++) begin
            taps_in[i] = taps_ff[i-1];
         end
         if (fill_ff != FILL_W'(DEPTH)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            taps_ff[i] <= '0;
         end
         fill_ff <= '0;
      end else begin
         taps_ff <= taps_in;
         fill_ff <= fill_in;
      end
   end

   assign taps = taps_ff;
   assign fill = fill_ff;

endmodule

// ===== design/fdl_interp.sv =====
// Delay clamp, tap selection and linear interpolation for one read word.
// Depends on fdl_pkg.
`timescale 1ns / 1ps

module fdl_interp
   import fdl_pkg::*;
(
   input  sample_type         taps [DEPTH],
   input  logic [FILL_W-1:0]  fill,
   input  logic [DELAY_W-1:0] delay,
   output result_type         result
);

   logic [DELAY_W-1:0]            delay_c;
   logic [WHOLE_W-1:0]            whole;
   logic [FRAC_W-1:0]             frac;
   logic [TAP_W-1:0]              idx_a;
   logic [TAP_W-1:0]              idx_b;
   sample_type                    tap_a;
   sample_type                    tap_b;
   logic signed [SAMPLE_W:0]      diff;
   logic signed [FRAC_W:0]        frac_s;
   logic signed [SAMPLE_W+FRAC_W+1:0] prod;
   logic signed [SAMPLE_W+FRAC_W+1:0] sum;
   logic                          enough;

   always_comb begin
      delay_c = (delay > DELAY_MAX) ? DELAY_MAX : delay;
      whole   = delay_c[DELAY_W-1:FRAC_W];
      frac    = delay_c[FRAC_W-1:0];
      idx_a   = TAP_W'(whole);
      // next older slot wraps onto the newest tap at the far end
      idx_b   = (idx_a == TAP_W'(DEPTH - 1)) ? '0 : idx_a + TAP_W'(1);
      tap_a   = taps[idx_a];
      tap_b   = taps[idx_b];
      enough  = fill > FILL_W'(whole);

      // a*(256-f) + b*f folded into a*256 + (b-a)*f
      diff   = {tap_b[SAMPLE_W-1], tap_b} - {tap_a[SAMPLE_W-1], tap_a};
      frac_s = {1'b0, frac};
      prod   = diff * frac_s;
      sum    = {{2{tap_a[SAMPLE_W-1]}}, tap_a, {FRAC_W{1'b0}}} + prod;

      result.enough = enough;
      if (!enough) begin
         result.value = '0;
      end else if (frac < FRAC_MIN) begin
         result.value = tap_a;
      end else begin
         result.value = sum[SAMPLE_W+FRAC_W-1:FRAC_W];
      end
   end

endmodule

// ===== design/fractional_delay_line_unit.sv =====
// Top level of the fractional delay line: input register, tap line,
// interpolator and result register. Depends on fdl_pkg, fdl_tap_line, fdl_interp.
//
// Usage:
//   req channel: one word per item. tuser selects push (0) or read (1).
//   A push stores tdata sample into the delay line and gives no result.
//   A read returns the sample delay (Q3.8, clamped to 5.0) pushes back,
//   linearly interpolated with the next older sample when the fraction
//   is at least 3/256. With too few samples stored the result is zero
//   and rsp_tuser (enough_data) is low.
//   A read waits in the input register, then its result waits in the result
//   register until rsp_tready takes it.
//   Throughput: one word per cycle on req while no read is stalled behind
//   a held result, set by the single pass from the input register through
//   tap select and one 17x9 multiply into the result register.
//   Reset clears the tap line, the fill count and the valid flags of both
//   pipeline registers; req_tready is high in the cycle after reset.
//   When rsp_tready is low, the result holds and a read waiting behind it
//   stalls; pushes keep flowing since they give no result.
`timescale 1ns / 1ps

module fractional_delay_line_unit
   import fdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] sample, [26:16] delay, rest zero
   input  logic                  req_tuser,  // [0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,  // [15:0] delayed_value
   output logic                  rsp_tuser   // [0] enough_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   kind_type           s1_kind_ff;
   sample_type         s1_sample_ff;
   logic [DELAY_W-1:0] s1_delay_ff;
   logic               s1_advance;
   logic               s1_is_read;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         rsp_result_ff;

   push_type           push;
   sample_type         taps [DEPTH];
   logic [FILL_W-1:0]  fill;
   result_type         result;
   logic               req_accept;

   assign s1_is_read = (s1_kind_ff == KIND_READ);
   assign s1_advance = s1_valid_ff && (!s1_is_read || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   assign push.push   = s1_advance && !s1_is_read;
   assign push.sample = s1_sample_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= kind_type'(req_tuser);
         s1_sample_ff <= req_tdata[SAMPLE_W-1:0];
         s1_delay_ff  <= req_tdata[SAMPLE_W+DELAY_W-1:SAMPLE_W];
      end
      if (s1_advance && s1_is_read) begin
         rsp_result_ff <= result;
      end
   end

   fdl_tap_line u_tap_line (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .taps  (taps),
      .fill  (fill)
   );

   fdl_interp u_interp (
      .taps   (taps),
      .fill   (fill),
      .delay  (s1_delay_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_result_ff.value;
   assign rsp_tuser  = rsp_result_ff.enough;

endmodule

// ===== design/fdl_checker.sv =====
// Port-level checks for the fractional delay line, bound to the top level.
// Depends on fdl_pkg and fractional_delay_line_unit.
`timescale 1ns / 1ps

module fdl_checker
   import fdl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [SAMPLE_W-1:0]   rsp_tdata,
   input logic                  rsp_tuser
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // too few samples always reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("result without enough data is not zero");

   // input stalls only behind a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready after reset");

endmodule

bind fractional_delay_line_unit fdl_checker u_fdl_checker (.*);

// ===== tb/fdl_delay_checker.sv =====
// Checker for the fractional delay line: watches the req and rsp channels, keeps its own
// copy of the sample ring and compares every rsp word with the predicted read result.
// Depends on fdl_pkg only.
`timescale 1ns / 1ps

module fdl_delay_checker
   import fdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [SAMPLE_W-1:0]   rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    fail_count,
   output int                    awaited,
   output int                    results_seen
);

   sample_type        ring [DEPTH];
   logic [TAP_W-1:0]  newest;
   logic [FILL_W-1:0] fill;
   result_type        tap_results_q [$];
   result_type        want;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Expected read word for the current ring contents.
   function automatic result_type predict_tap(input logic [DELAY_W-1:0] delay);
      logic [DELAY_W-1:0] d;
      int                 whole;
      int                 frac;
      int                 pos;
      int                 a;
      int                 b;
      int                 acc;
      result_type         r;
      d = (delay > DELAY_MAX) ? DELAY_MAX : delay;
      whole = int'(d >> FRAC_W);
      frac = int'(d[FRAC_W-1:0]);
      if (int'(fill) <= whole) begin
         r.value = '0;
         r.enough = 1'b0;
         return r;
      end
      pos = (int'(newest) + DEPTH - whole) % DEPTH;
      a = ring[pos];
      if (frac < int'(FRAC_MIN)) begin
         r.value = a[SAMPLE_W-1:0];
      end else begin
         // blend with the next older slot, floor on the shift
         b = ring[(pos + DEPTH - 1) % DEPTH];
         acc = a * ((1 << FRAC_W) - frac) + b * frac;
         acc = acc >>> FRAC_W;
         r.value = acc[SAMPLE_W-1:0];
      end
      r.enough = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (ring[i]) ring[i] = '0;
         newest = TAP_W'(DEPTH - 1);
         fill = '0;
         tap_results_q.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (tap_results_q.size() == 0) begin
               report_mismatch($sformatf("rsp word %0d with no read waiting",
                                         $signed(rsp_tdata)));
            end else begin
               want = tap_results_q.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch($sformatf("delayed_value got %0d, want %0d",
                                            $signed(rsp_tdata), want.value));
               if (rsp_tuser !== want.enough)
                  report_mismatch($sformatf("enough_data got %b, want %b",
                                            rsp_tuser, want.enough));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_PUSH) begin
               newest = (newest == TAP_W'(DEPTH - 1)) ? '0 : newest + 1'b1;
               ring[newest] = req_tdata[SAMPLE_W-1:0];
               if (fill < FILL_W'(DEPTH)) fill = fill + 1'b1;
            end else begin
               tap_results_q.push_back(predict_tap(req_tdata[SAMPLE_W +: DELAY_W]));
            end
         end
      end
      awaited = tap_results_q.size();
   end

endmodule

// ===== tb/tb_fractional_delay_line_unit.sv =====
// Testbench top for fractional_delay_line_unit: drives push and read words with random
// gaps and back-pressure; gives the verdict. Needs fdl_pkg, the unit, fdl_delay_checker.
`timescale 1ns / 1ps

module tb_fractional_delay_line_unit;
   import fdl_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES  = 80;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [15:0] sample, [26:16] delay, rest zero
   logic                  req_tuser = 1'b0;  // [0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;  // [15:0] delayed_value
   logic                  rsp_tuser;  // [0] enough_data

   int fail_count;
   int awaited;
   int results_seen;
   int pushes_sent = 0;
   int reads_sent = 0;
   int quiet_cycles = 0;
   bit send_idle = 1'b1;
   bit take_idle = 1'b1;

   fractional_delay_line_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fdl_delay_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .awaited      (awaited),
      .results_seen (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // End the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_word(input kind_type kind, input sample_type sample,
                            input logic [DELAY_W-1:0] delay);
      int gap;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = '0;
      req_tdata[SAMPLE_W-1:0] = sample;
      req_tdata[SAMPLE_W +: DELAY_W] = delay;
      req_tuser = kind;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == KIND_PUSH) pushes_sent++;
      else reads_sent++;
   endtask

   function automatic sample_type draw_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Mostly in range, some above the clamp, some with a fraction too small to blend.
   function automatic logic [DELAY_W-1:0] draw_delay();
      case ($urandom_range(0, 9))
         0:       return DELAY_W'($urandom_range(1281, 2047));
         1:       return DELAY_W'(($urandom_range(0, 5) << FRAC_W) + $urandom_range(0, 2));
         default: return DELAY_W'($urandom_range(0, 1280));
      endcase
   endfunction

   // Receiver: random wait per word, two long hold-offs so the pipeline backs up.
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == 40 || taken == 200) gap = HOLD_CYCLES;
         else gap = take_idle ? $urandom_range(0, 9) : 0;
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         taken++;
         if (taken % 30 == 0) take_idle = $urandom_range(0, 1);
      end
   end

   initial begin
      kind_type kind;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reads on an empty line, one of them above the clamp
      send_word(KIND_READ, 16'shFFFF, 11'd0);
      send_word(KIND_READ, 16'sh0000, 11'h7FF);
      send_word(KIND_PUSH, 16'sh7FFF, 11'h7FF);
      // blend with a slot that was never written
      send_word(KIND_READ, 16'sh0000, 11'h080);
      send_word(KIND_PUSH, 16'sh8000, 11'h000);
      send_word(KIND_READ, 16'sh0000, 11'h100);
      send_word(KIND_READ, 16'sh0000, 11'h200);
      send_word(KIND_READ, 16'sh0000, 11'h0FF);
      send_word(KIND_PUSH, 16'sh0000, 11'h555);
      send_word(KIND_PUSH, 16'shFFFF, 11'h2AA);
      send_word(KIND_PUSH, 16'sh0001, 11'h000);
      send_word(KIND_PUSH, 16'sd12345, 11'h7FF);
      // wrap the ring, fill count saturates
      send_word(KIND_PUSH, -16'sd12345, 11'h000);
      send_word(KIND_READ, 16'shFFFF, 11'h000);
      send_word(KIND_READ, 16'sh0000, 11'h002);
      send_word(KIND_READ, 16'sh0000, 11'h003);
      send_word(KIND_READ, 16'sh0000, 11'h4FF);
      send_word(KIND_READ, 16'sh0000, 11'd1280);
      send_word(KIND_READ, 16'sh0000, 11'd1281);
      send_word(KIND_READ, 16'sh0000, 11'd2047);
      send_word(KIND_READ, 16'sh0000, 11'h280);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) send_idle = $urandom_range(0, 1);
         kind = $urandom_range(0, 1) ? KIND_READ : KIND_PUSH;
         if (kind == KIND_PUSH)
            send_word(kind, draw_sample(), DELAY_W'($urandom));
         else
            send_word(kind, sample_type'($urandom), draw_delay());
      end
      req_tvalid = 1'b0;

      while (awaited != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d pushes and %0d reads with random gaps and two long rsp hold-offs;",
               pushes_sent, reads_sent);
      $display("compared %0d result words, %0d mismatches.", results_seen, fail_count);
      if (fail_count == 0 && awaited == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/fdl_pkg.sv
design/fdl_tap_line.sv
design/fdl_interp.sv
design/fractional_delay_line_unit.sv
design/fdl_checker.sv
tb/fdl_delay_checker.sv
tb/tb_fractional_delay_line_unit.sv
